// ===== design/lph_pkg.sv =====
// Shared types and constants for the linear-probing hash insert block.
package lph_pkg;

    // Fixed field widths of the stream payload
    localparam int SLOT_W   = 7;
    localparam int SIZE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Remainder bits retired per cycle by the modulo unit
    localparam int MOD_STEP_BITS = 4;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_READ     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 2'd3;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_READ_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== design/lph_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lph_mod.sv =====
// Iterative remainder unit: key modulo table size, several bits per cycle.
module lph_mod
    import lph_pkg::*;
#(
    parameter int KEY_WIDTH = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [KEY_WIDTH-1:0] dividend,
    input  logic [SIZE_W-1:0]    divisor,
    output logic                 done,
    output logic [SIZE_W-1:0]    remainder
);

    localparam int STEPS = (KEY_WIDTH + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
    localparam int PAD_W = STEPS * MOD_STEP_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PAD_W-1:0]  sh_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] div_reg;
    logic [SIZE_W-1:0] rem_next;

    // Restoring remainder, MSB first; rem stays below div so trial fits 9 bits
    always_comb
    begin
        logic [SIZE_W:0]   trial;
        logic [SIZE_W-1:0] acc;
        acc = rem_reg;
        for (int i = 0; i < MOD_STEP_BITS; i++)
        begin
            trial = {acc, sh_reg[PAD_W-1-i]};
            if (trial >= {1'b0, div_reg})
            begin
                acc = SIZE_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                acc = trial[SIZE_W-1:0];
            end
        end
        rem_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= PAD_W'(dividend);
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_reg << MOD_STEP_BITS;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/linear_probe_hash_insert.sv =====
// Hash table with open addressing and linear probing: top level.
//
// Requests enter on the s_* stream (operation in s_tuser), one result per
// request leaves on the m_* stream (status in m_tuser); operation 3 is taken
// and dropped without a result. One request is worked on at a time.
// cfg_wr_en/cfg_wr_data set the number of slots in use (0 acts as 1, values
// above TABLE_DEPTH act as TABLE_DEPTH); write it only while idle.
// Slot keys and used flags share one RAM with a registered read.
// Work per request after accept:
//   insert: the remainder unit retires 4 bits a cycle, then each probe is
//           a RAM read plus a check
//   read:   one RAM read of the requested slot
//   clear:  one RAM row written per cycle over all TABLE_DEPTH rows
// After reset the same clearing pass runs with s_tready low and no
// result; table size resets to 128.
// The result sits in an output register, so a stalled m_tready does not
// stop the next request from being taken and worked on; it only holds the
// following result back until the register drains.
module linear_probe_hash_insert
    import lph_pkg::*;
#(
    parameter int TABLE_DEPTH = 128,
    parameter int KEY_WIDTH   = 31
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    // table_size
    input  logic                                         cfg_wr_en,
    input  logic [SIZE_W-1:0]                            cfg_wr_data,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // key, slot_index, zero pad
    input  logic [((KEY_WIDTH + SLOT_W + 7) / 8) * 8-1:0] s_tdata,
    // operation
    input  logic [OP_W-1:0]                              s_tuser,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // placed_slot, slot_key, slot_used, zero pad
    output logic [((SLOT_W + KEY_WIDTH + 8) / 8) * 8-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]                          m_tuser
);

    localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int M_DATA_W = ((SLOT_W + KEY_WIDTH + 8) / 8) * 8;
    localparam int RAM_W    = KEY_WIDTH + 1;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]    table_size_reg;
    logic [SIZE_W-1:0]    eff_size;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 clr_reply_reg;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 in_range_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [SIZE_W-1:0]    pos_reg;
    logic [SIZE_W-1:0]    probe_cnt_reg;

    logic [STATUS_W-1:0]  res_status_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [KEY_WIDTH-1:0] res_key_reg;
    logic                 res_used_reg;

    logic                 m_tvalid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic [KEY_WIDTH-1:0] m_key_reg;
    logic                 m_used_reg;

    logic [OP_W-1:0]      in_op;
    logic [KEY_WIDTH-1:0] in_key;
    logic [SLOT_W-1:0]    in_slot_index;
    logic                 s_acc;
    logic                 out_load;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [RAM_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [RAM_W-1:0]     ram_rdata;
    logic                 rd_used;
    logic [KEY_WIDTH-1:0] rd_key;
    logic                 probe_last;

    logic                 mod_start;
    logic                 mod_done;
    logic [SIZE_W-1:0]    mod_rem;

    assign in_op         = s_tuser;
    assign in_key        = s_tdata[KEY_WIDTH-1:0];
    assign in_slot_index = s_tdata[KEY_WIDTH +: SLOT_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign mod_start = s_acc && (in_op == OP_INSERT);
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    assign rd_used    = ram_rdata[KEY_WIDTH];
    assign rd_key     = ram_rdata[KEY_WIDTH-1:0];
    assign probe_last = (probe_cnt_reg == size_reg - SIZE_W'(1));

    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (int'(table_size_reg) > TABLE_DEPTH)
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    lph_mod #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_key),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lph_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (in_op)
                        OP_INSERT: state_next = ST_MOD;
                        OP_READ:   state_next = ST_READ_WAIT;
                        OP_CLEAR:  state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = clr_reply_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD:
            begin
                state_next = ST_PROBE_CHK;
            end
            ST_PROBE_CHK:
            begin
                if (!rd_used || probe_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = AW'(pos_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_re    = s_acc && (in_op == OP_READ);
                ram_raddr = AW'(in_slot_index);
            end
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_PROBE_RD:
            begin
                ram_re = 1'b1;
            end
            ST_PROBE_CHK:
            begin
                ram_we    = !rd_used;
                ram_waddr = AW'(pos_reg);
                ram_wdata = {1'b1, key_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            table_size_reg <= TABLE_SIZE_RESET;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (s_acc && (in_op == OP_CLEAR))
            begin
                clr_reply_reg <= 1'b1;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            key_reg        <= in_key;
            idx_reg        <= in_slot_index;
            in_range_reg   <= (int'(in_slot_index) < TABLE_DEPTH);
            size_reg       <= eff_size;
            res_status_reg <= STAT_CLEARED;
            res_slot_reg   <= '0;
            res_key_reg    <= '0;
            res_used_reg   <= 1'b0;
        end
        if ((state_reg == ST_MOD) && mod_done)
        begin
            pos_reg       <= mod_rem;
            probe_cnt_reg <= '0;
        end
        if (state_reg == ST_PROBE_CHK)
        begin
            if (!rd_used)
            begin
                res_status_reg <= STAT_INSERTED;
                res_slot_reg   <= SLOT_W'(pos_reg);
            end
            else if (probe_last)
            begin
                res_status_reg <= STAT_DROPPED;
                res_slot_reg   <= '0;
            end
            else
            begin
                // wrap within the slots in use
                pos_reg       <= (pos_reg + SIZE_W'(1) == size_reg) ? '0
                                 : pos_reg + SIZE_W'(1);
                probe_cnt_reg <= probe_cnt_reg + SIZE_W'(1);
            end
        end
        if (state_reg == ST_READ_WAIT)
        begin
            res_status_reg <= STAT_READ;
            res_slot_reg   <= idx_reg;
            res_used_reg   <= in_range_reg && rd_used;
            res_key_reg    <= (in_range_reg && rd_used) ? rd_key : '0;
        end
        if (out_load)
        begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_key_reg    <= res_key_reg;
            m_used_reg   <= res_used_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_DATA_W'({m_used_reg, m_key_reg, m_slot_reg});

endmodule

// ===== sim/linear_probe_hash_insert_tb.sv =====
// Self-checking testbench for the linear-probing hash insert block.
`timescale 1ns / 100ps

module linear_probe_hash_insert_tb;
    import lph_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int KEY_W       = 31;
    localparam int IN_W        = ((KEY_W + SLOT_W + 7) / 8) * 8;
    localparam int OUT_W       = ((SLOT_W + KEY_W + 8) / 8) * 8;
    localparam int SETTLE      = 300;       // longer than the slowest insert
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 12;

    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] idx;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
        logic                used;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [SIZE_W-1:0]  cfg_wr_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // key, slot_index, zero pad
    logic [IN_W-1:0]    s_tdata = '0;
    // operation
    logic [OP_W-1:0]    s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // placed_slot, slot_key, slot_used, zero pad
    logic [OUT_W-1:0]   m_tdata;
    // status
    logic [STATUS_W-1:0] m_tuser;

    request_t request_q[$];
    outcome_t outcome_q[$];

    // shadow of the table contents and of the size register
    logic [KEY_W-1:0]  shadow_key [TABLE_DEPTH];
    bit                shadow_used [TABLE_DEPTH];
    logic [SIZE_W-1:0] shadow_size = TABLE_SIZE_RESET;

    int  errors = 0;
    int  cycle_cnt = 0;
    bit  s_taken = 1'b0;
    bit  quiet = 1'b0;

    int  src_gap = 0;
    int  src_stretch = 0;
    bit  src_noisy = 1'b0;
    int  snk_stall = 0;
    int  snk_stretch = 0;
    bit  snk_noisy = 1'b0;

    linear_probe_hash_insert #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_W)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // zero acts as one slot, oversize acts as the full table
    function automatic int unsigned slots_in_use(input logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > TABLE_DEPTH)
            return TABLE_DEPTH;
        return v;
    endfunction

    function automatic void hash_table_step(input request_t r);
        outcome_t    o;
        int unsigned n_slots;
        int unsigned pos;
        int unsigned n;
        bit          placed;
        o = '0;
        case (r.op)
            OP_INSERT:
            begin
                n_slots  = slots_in_use(shadow_size);
                pos      = r.key % n_slots;
                placed   = 1'b0;
                o.status = STAT_DROPPED;
                for (n = 0; n < n_slots && !placed; n++)
                begin
                    if (!shadow_used[pos])
                    begin
                        shadow_used[pos] = 1'b1;
                        shadow_key[pos]  = r.key;
                        o.status         = STAT_INSERTED;
                        o.slot           = pos[SLOT_W-1:0];
                        placed           = 1'b1;
                    end
                    else
                        pos = (pos + 1 == n_slots) ? 0 : pos + 1;
                end
                outcome_q.push_back(o);
            end
            OP_READ:
            begin
                o.status = STAT_READ;
                o.slot   = r.idx;
                if (shadow_used[r.idx])
                begin
                    o.key  = shadow_key[r.idx];
                    o.used = 1'b1;
                end
                outcome_q.push_back(o);
            end
            OP_CLEAR:
            begin
                for (n = 0; n < TABLE_DEPTH; n++)
                begin
                    shadow_used[n] = 1'b0;
                    shadow_key[n]  = '0;
                end
                o.status = STAT_CLEARED;
                outcome_q.push_back(o);
            end
            default:
                ;   // unknown operation: taken, no result
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= 40)
            $display("mismatch: %s expected 0x%0h got 0x%0h at %0t ns",
                     what, want, got, $time);
    endtask

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [SLOT_W-1:0] idx);
        request_t r;
        r.op  = op;
        r.key = key;
        r.idx = idx;
        request_q.push_back(r);
    endtask

    // random requests, mostly inserts and reads; keys cluster on a hot home slot
    task automatic queue_random(input int n, input int clr_pct, input int unsigned slots);
        request_t    r;
        int          made;
        int          pick;
        int unsigned hot;
        made = 0;
        hot  = $urandom_range(0, slots - 1);
        while (made < n)
        begin
            r.key = KEY_W'($urandom());
            r.idx = SLOT_W'($urandom());
            pick  = $urandom_range(0, 99);
            if (pick < clr_pct)
            begin
                r.op = OP_CLEAR;
                made++;
            end
            else if (pick < clr_pct + 3)
                r.op = OP_UNUSED;
            else if (pick < clr_pct + 35)
            begin
                r.op = OP_READ;
                if ($urandom_range(0, 9) < 7)
                    r.idx = SLOT_W'($urandom_range(0, slots - 1));
                made++;
            end
            else
            begin
                r.op = OP_INSERT;
                case ($urandom_range(0, 9))
                    5, 6:    r.key = KEY_W'($urandom_range(0, 3 * slots));
                    7, 8:    r.key = KEY_W'($urandom_range(0, 50000) * slots + hot);
                    9:       r.key = ($urandom_range(0, 1) != 0) ? KEY_MAX
                                     : KEY_W'($urandom_range(0, 1));
                    default: ;
                endcase
                made++;
            end
            request_q.push_back(r);
        end
    endtask

    // nothing queued, nothing in flight, then room for a resultless request
    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // request side: new data only after the previous request was taken
    always @(negedge clk)
    begin : request_driver
        request_t r;
        logic     v;
        v = s_tvalid;
        if (src_stretch == 0)
        begin
            src_stretch = $urandom_range(20, 300);
            src_noisy   = ($urandom_range(0, 2) != 0);
        end
        else
            src_stretch--;
        if (rst_n && (!s_tvalid || s_taken))
        begin
            v = 1'b0;
            if (src_gap > 0)
                src_gap--;
            else if (request_q.size() != 0)
            begin
                if (!quiet && src_noisy && $urandom_range(0, 5) == 0)
                    src_gap = $urandom_range(1, 12) - 1;
                else
                begin
                    r = request_q.pop_front();
                    s_tdata <= {{(IN_W - KEY_W - SLOT_W){1'b0}}, r.idx, r.key};
                    s_tuser <= r.op;
                    v = 1'b1;
                end
            end
        end
        s_tvalid <= v;
    end

    // result side backpressure
    always @(negedge clk)
    begin : result_sink
        logic rdy;
        rdy = 1'b1;
        if (snk_stretch == 0)
        begin
            snk_stretch = $urandom_range(20, 300);
            snk_noisy   = ($urandom_range(0, 2) != 0);
        end
        else
            snk_stretch--;
        if (snk_stall > 0)
        begin
            snk_stall--;
            rdy = 1'b0;
        end
        else if (!quiet && snk_noisy && $urandom_range(0, 5) == 0)
        begin
            snk_stall = $urandom_range(1, 12) - 1;
            rdy = 1'b0;
        end
        m_tready <= rdy;
    end

    always @(posedge clk)
    begin : monitor
        request_t r;
        outcome_t got;
        outcome_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        if (!rst_n)
            s_taken <= 1'b0;
        else
        begin
            if (cfg_wr_en)
                shadow_size = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.slot   = m_tdata[SLOT_W-1:0];
                got.key    = m_tdata[SLOT_W+KEY_W-1:SLOT_W];
                got.used   = m_tdata[SLOT_W+KEY_W];
                if (outcome_q.size() == 0)
                    report_mismatch("result with no request pending", 0, got);
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.slot != want.slot)
                        report_mismatch("placed_slot", want.slot, got.slot);
                    if (got.key != want.key)
                        report_mismatch("slot_key", want.key, got.key);
                    if (got.used != want.used)
                        report_mismatch("slot_used", want.used, got.used);
                end
            end
            if (s_tvalid && s_tready)
            begin
                r.op  = s_tuser;
                r.key = s_tdata[KEY_W-1:0];
                r.idx = s_tdata[KEY_W+SLOT_W-1:KEY_W];
                hash_table_step(r);
            end
            s_taken <= s_tvalid && s_tready;
        end
    end

    initial
    begin : stimulus
        int unsigned size_plan [PHASES];
        int          clr_plan [PHASES];
        int          ph;
        size_plan = '{128, 1, 0, 255, 129, 2, 16, 127, 128, 5, 100, 64};
        clr_plan  = '{3, 6, 6, 2, 1, 8, 2, 1, 1, 5, 2, 3};
        for (ph = 0; ph < TABLE_DEPTH; ph++)
        begin
            shadow_key[ph]  = '0;
            shadow_used[ph] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a clear first, so every slot holds a defined key before any read
        queue_request(OP_CLEAR, '0, '0);
        queue_request(OP_INSERT, '0, '0);
        queue_request(OP_INSERT, KEY_MAX, '0);
        queue_request(OP_INSERT, 31'd128, '0);             // home 0 taken
        queue_request(OP_INSERT, 31'd255, '0);             // wraps past 127 and 0
        queue_request(OP_INSERT, 31'h5555_5555, '0);
        queue_request(OP_INSERT, 31'h2AAA_AAAA, '0);
        queue_request(OP_READ, '0, 7'd0);
        queue_request(OP_READ, '0, 7'd127);
        queue_request(OP_READ, '0, 7'd1);
        queue_request(OP_READ, '0, 7'd2);
        queue_request(OP_READ, '0, 7'h55);
        queue_request(OP_READ, KEY_MAX, 7'h2A);
        queue_request(OP_READ, '0, 7'd64);                 // empty slot
        queue_request(OP_UNUSED, KEY_MAX, 7'd127);
        queue_request(OP_READ, KEY_MAX, 7'd127);
        queue_request(OP_CLEAR, KEY_MAX, 7'd127);
        queue_request(OP_READ, '0, 7'd0);
        queue_request(OP_INSERT, 31'd1, 7'd127);
        queue_request(OP_READ, '0, 7'd1);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_idle();
                @(negedge clk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= SIZE_W'(size_plan[ph]);
                @(negedge clk);
                cfg_wr_en   <= 1'b0;
            end
            if (ph == PHASES - 1)
                quiet = 1'b1;
            queue_random(150, clr_plan[ph], slots_in_use(SIZE_W'(size_plan[ph])));
        end
        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/lph_pkg.sv
design/lph_ram.sv
design/lph_mod.sv
design/linear_probe_hash_insert.sv
sim/linear_probe_hash_insert_tb.sv
